// ----- src/k_way_merge_heap_defines.svh -----
// ----------------------------------------------------------------------------
// k_way_merge_heap_defines
// Assertion macros shared by the merge heap RTL. They expect clk and rst.
// ----------------------------------------------------------------------------
`ifndef K_WAY_MERGE_HEAP_DEFINES_SVH
`define K_WAY_MERGE_HEAP_DEFINES_SVH

// Condition holds at every edge out of reset
`define KWM_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define KWM_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- src/kwm_pkg.sv -----
// ----------------------------------------------------------------------------
// kwm_pkg
// Types and constants for the k-way merge heap.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int LISTS      = 8;
  localparam int LIST_DEPTH = 256;
  localparam int KEY_W      = 32;

  localparam int LIST_W  = $clog2(LISTS);
  localparam int POS_W   = $clog2(LIST_DEPTH);
  localparam int LEN_W   = $clog2(LIST_DEPTH + 1);
  localparam int CNT_W   = $clog2(LISTS + 1);
  localparam int CHILD_W = LIST_W + 1;
  localparam int ADDR_W  = LIST_W + POS_W;
  localparam int STORE_DEPTH = LISTS * LIST_DEPTH;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_POP   = 2'd2,
    OP_CLEAR = 2'd3
  } op_e_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_PHASE = 2'd3
  } status_t;

  typedef enum logic {
    PH_LOADING = 1'b0,
    PH_MERGING = 1'b1
  } phase_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [LIST_W-1:0]       src;
    logic [POS_W-1:0]        pos;
  } entry_t;

endpackage

// ----- src/kwm_req_if.sv -----
// ----------------------------------------------------------------------------
// kwm_req_if
// Command channel of the merge heap: op, value and list id.
// ----------------------------------------------------------------------------
interface kwm_req_if;
  import kwm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              op;
  logic signed [KEY_W-1:0] value;
  logic [LIST_W-1:0]       list_id;

  modport source (output valid, op, value, list_id, input ready);
  modport sink   (input valid, op, value, list_id, output ready);
endinterface

// ----- src/kwm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// kwm_rsp_if
// Result channel of the merge heap: popped value, list, last flag, status.
// ----------------------------------------------------------------------------
interface kwm_rsp_if;
  import kwm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [KEY_W-1:0] out_value;
  logic [LIST_W-1:0]       out_list;
  logic                    is_last;
  logic [1:0]              status;

  modport source (output valid, out_value, out_list, is_last, status, input ready);
  modport sink   (input valid, out_value, out_list, is_last, status, output ready);
endinterface

// ----- src/k_way_merge_heap.sv -----
// ----------------------------------------------------------------------------
// k_way_merge_heap
// Merges up to eight ascending lists of signed 32-bit values through a binary
// min-heap holding one head per list.
// ----------------------------------------------------------------------------
// Every command returns exactly one item. Loads, clears and rejected commands
// go from the idle state straight to the reply state. A pop replies after a
// sift-down from the root when entries remain (at most two swaps), then, when
// the popped list refills, an element store read and a sift-up (at most three
// swaps and a final parent compare). A start scans the eight lists one per
// cycle, pausing at each non-empty list to read its head from the element
// store and sift it up, and replies once the scan ends.
// Every key compare runs on the one shared comparator. The element store is a
// 2048-entry RAM with registered read; the heap is eight registers read
// through a single mux. Commands are accepted only while the sequencer is
// idle, and a reply waits in its output register while the receiver stalls.
// ----------------------------------------------------------------------------
module k_way_merge_heap (
  input logic   clk,
  input logic   rst,
  kwm_req_if.sink   req,
  kwm_rsp_if.source rsp
);
  import kwm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_FETCH = 8'b0000_0100,
    S_UP    = 8'b0000_1000,
    S_DNL   = 8'b0001_0000,
    S_DNR   = 8'b0010_0000,
    S_FILL  = 8'b0100_0000,
    S_EMIT  = 8'b1000_0000
  } state_t;

  state_t            state;
  phase_t            phase;
  logic [CNT_W-1:0]  count;
  logic [LEN_W-1:0]  len [LISTS];
  entry_t            heap [LISTS];
  entry_t            cur;
  entry_t            cand;
  logic              moved;
  logic [LIST_W-1:0] idx;
  logic [CNT_W-1:0]  scan;
  logic              building;
  logic [LIST_W-1:0] pop_src;
  logic [POS_W-1:0]  pop_pos;
  logic [LIST_W-1:0] fsrc;
  logic [POS_W-1:0]  fpos;

  logic signed [KEY_W-1:0] res_value;
  logic [LIST_W-1:0]       res_list;
  logic                    res_pop;
  status_t                 res_status;

  logic                    o_valid;
  logic signed [KEY_W-1:0] o_value;
  logic [LIST_W-1:0]       o_list;
  logic                    o_last;
  status_t                 o_status;

  logic              hp_we;
  logic [LIST_W-1:0] hp_waddr;
  entry_t            hp_wdata;
  logic [LIST_W-1:0] hp_raddr;
  entry_t            hp_rd;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [KEY_W-1:0]   ram_rdata;

  logic [CHILD_W-1:0] lch;
  logic [CHILD_W-1:0] rch;
  logic [LIST_W-1:0]  parent;
  logic               l_ok;
  logic               up_swap;
  logic signed [KEY_W-1:0] dn_mk;
  logic signed [KEY_W-1:0] cmp_a;
  logic signed [KEY_W-1:0] cmp_b;
  logic               key_gt;
  logic               r_take;
  logic               dn_stop;
  entry_t             dn_pick;
  logic [LIST_W-1:0]  dn_m;
  logic [LEN_W-1:0]   fill_next;
  logic               fill_ok;
  logic               scan_end;
  logic               accept;
  logic               load_ok;
  logic               emit_go;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;

  assign rsp.valid     = o_valid;
  assign rsp.out_value = o_value;
  assign rsp.out_list  = o_list;
  assign rsp.is_last   = o_last;
  assign rsp.status    = o_status;

  assign emit_go = (state == S_EMIT) && (!o_valid || rsp.ready);

  assign lch    = {idx, 1'b1};
  assign rch    = lch + CHILD_W'(1);
  assign parent = LIST_W'((idx - LIST_W'(1)) >> 1);
  assign l_ok   = ({1'b0, lch} < {1'b0, count});

  always_comb begin
    unique case (state)
      S_IDLE:  hp_raddr = LIST_W'(count - CNT_W'(1));
      S_UP:    hp_raddr = parent;
      S_DNL:   hp_raddr = lch[LIST_W-1:0];
      S_DNR:   hp_raddr = rch[LIST_W-1:0];
      default: hp_raddr = '0;
    endcase
  end

  assign hp_rd   = heap[hp_raddr];
  assign dn_mk   = moved ? cand.key : cur.key;
  assign cmp_a   = (state == S_UP) ? hp_rd.key : ((state == S_DNR) ? dn_mk : cur.key);
  assign cmp_b   = (state == S_UP) ? cur.key : hp_rd.key;
  assign key_gt  = (cmp_a > cmp_b);
  assign up_swap = (idx != '0) && key_gt;
  assign r_take  = ({1'b0, rch} < {1'b0, count}) && key_gt;
  assign dn_stop = !moved && !r_take;
  assign dn_pick = r_take ? hp_rd : cand;
  assign dn_m    = r_take ? rch[LIST_W-1:0] : lch[LIST_W-1:0];

  always_comb begin
    hp_we    = 1'b0;
    hp_waddr = idx;
    hp_wdata = cur;
    unique case (state)
      S_UP: begin
        hp_we    = 1'b1;
        hp_wdata = up_swap ? hp_rd : cur;
      end
      S_DNL: begin
        hp_we = !l_ok;
      end
      S_DNR: begin
        hp_we    = 1'b1;
        hp_wdata = dn_stop ? cur : dn_pick;
      end
      default: hp_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (hp_we) begin
      heap[hp_waddr] <= hp_wdata;
    end
  end

  assign fill_next = {1'b0, pop_pos} + LEN_W'(1);
  assign fill_ok   = fill_next < len[pop_src];
  assign scan_end  = (scan == CNT_W'(LISTS));

  assign load_ok   = (phase == PH_LOADING) && (len[req.list_id] < LEN_W'(LIST_DEPTH));
  assign ram_we    = accept && (op_e_t'(req.op) == OP_LOAD) && load_ok;
  assign ram_waddr = {req.list_id, len[req.list_id][POS_W-1:0]};
  assign ram_re    = ((state == S_SCAN) && !scan_end && (len[scan[LIST_W-1:0]] != '0)) ||
                     ((state == S_FILL) && fill_ok);
  assign ram_raddr = (state == S_SCAN) ? {scan[LIST_W-1:0], {POS_W{1'b0}}}
                                       : {pop_src, fill_next[POS_W-1:0]};

  kwm_ram #(
    .WIDTH (KEY_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req.value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      phase   <= PH_LOADING;
      count   <= '0;
      o_valid <= 1'b0;
      for (int i = 0; i < LISTS; i++) begin
        len[i] <= '0;
      end
    end else begin
      if (emit_go) begin
        o_valid <= 1'b1;
      end else if (o_valid && rsp.ready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (op_e_t'(req.op))
              OP_LOAD: begin
                res_value <= '0;
                res_list  <= '0;
                res_pop   <= 1'b0;
                state     <= S_EMIT;
                if (phase != PH_LOADING) begin
                  res_status <= ST_PHASE;
                end else if (!load_ok) begin
                  res_status <= ST_FULL;
                end else begin
                  res_status       <= ST_OK;
                  len[req.list_id] <= len[req.list_id] + LEN_W'(1);
                end
              end
              OP_START: begin
                res_value <= '0;
                res_list  <= '0;
                res_pop   <= 1'b0;
                if (phase != PH_LOADING) begin
                  res_status <= ST_PHASE;
                  state      <= S_EMIT;
                end else begin
                  res_status <= ST_OK;
                  count      <= '0;
                  scan       <= '0;
                  building   <= 1'b1;
                  state      <= S_SCAN;
                end
              end
              OP_POP: begin
                if (phase != PH_MERGING || count == '0) begin
                  res_value  <= '0;
                  res_list   <= '0;
                  res_pop    <= 1'b0;
                  res_status <= (phase != PH_MERGING) ? ST_PHASE : ST_EMPTY;
                  state      <= S_EMIT;
                end else begin
                  res_value  <= heap[0].key;
                  res_list   <= heap[0].src;
                  res_pop    <= 1'b1;
                  res_status <= ST_OK;
                  pop_src    <= heap[0].src;
                  pop_pos    <= heap[0].pos;
                  building   <= 1'b0;
                  count      <= count - CNT_W'(1);
                  cur        <= hp_rd;
                  idx        <= '0;
                  state      <= (count == CNT_W'(1)) ? S_FILL : S_DNL;
                end
              end
              OP_CLEAR: begin
                res_value  <= '0;
                res_list   <= '0;
                res_pop    <= 1'b0;
                res_status <= ST_OK;
                state      <= S_EMIT;
                count      <= '0;
                phase      <= PH_LOADING;
                for (int i = 0; i < LISTS; i++) begin
                  len[i] <= '0;
                end
              end
              default: state <= S_EMIT;
            endcase
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            phase <= PH_MERGING;
            state <= S_EMIT;
          end else if (ram_re) begin
            fsrc  <= scan[LIST_W-1:0];
            fpos  <= '0;
            state <= S_FETCH;
          end else begin
            scan <= scan + CNT_W'(1);
          end
        end
        S_FETCH: begin
          cur   <= '{key: ram_rdata, src: fsrc, pos: fpos};
          idx   <= count[LIST_W-1:0];
          count <= count + CNT_W'(1);
          state <= S_UP;
        end
        S_UP: begin
          if (up_swap) begin
            idx <= parent;
          end else if (building) begin
            scan  <= scan + CNT_W'(1);
            state <= S_SCAN;
          end else begin
            state <= S_EMIT;
          end
        end
        S_DNL: begin
          if (l_ok) begin
            moved <= key_gt;
            cand  <= hp_rd;
            state <= S_DNR;
          end else begin
            state <= S_FILL;
          end
        end
        S_DNR: begin
          if (dn_stop) begin
            state <= S_FILL;
          end else begin
            idx   <= dn_m;
            state <= S_DNL;
          end
        end
        S_FILL: begin
          if (fill_ok) begin
            fsrc  <= pop_src;
            fpos  <= fill_next[POS_W-1:0];
            state <= S_FETCH;
          end else begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            o_value  <= res_value;
            o_list   <= res_list;
            o_last   <= res_pop && (count == '0);
            o_status <= res_status;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "k_way_merge_heap_defines.svh"

  `KWM_ALWAYS(a_count_range, count <= CNT_W'(LISTS), "heap count above list count")
  `KWM_IMPLY(a_load_empty, (state == S_IDLE) && (phase == PH_LOADING), count == '0, "heap not empty")
  `KWM_IMPLY(a_up_index, state == S_UP, {1'b0, idx} < count, "sift-up index outside heap")
  `KWM_IMPLY(a_last_empty, o_valid && o_last, count == '0, "last item flagged with heap not empty")

endmodule

// ----- src/kwm_ram.sv -----
// ----------------------------------------------------------------------------
// kwm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- verif/k_way_merge_heap_checker.sv -----
// ----------------------------------------------------------------------------
// k_way_merge_heap_checker
// Watches both channels of the merge heap. Each accepted command updates a
// private copy of the list stores and the min-heap, and its reply is queued.
// Each accepted reply is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module k_way_merge_heap_checker (
  input  logic clk,
  input  logic rst,
  kwm_req_if   req,
  kwm_rsp_if   rsp,
  output int   errors,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import kwm_pkg::*;

  typedef struct {
    logic signed [KEY_W-1:0] value;
    logic [LIST_W-1:0]       lst;
    logic                    last;
    status_t                 st;
  } merge_reply_t;

  logic signed [KEY_W-1:0] elem_mem [LISTS][LIST_DEPTH];
  int                      list_len [LISTS];
  entry_t                  heap_slot [LISTS];
  int                      heap_n;
  phase_t                  merge_phase;
  merge_reply_t            reply_q [$];
  int                      fail_total;

  function automatic void clear_model();
    for (int s = 0; s < LISTS; s++) list_len[s] = 0;
    heap_n      = 0;
    merge_phase = PH_LOADING;
  endfunction

  function automatic void swap_slots(int a, int b);
    entry_t t;
    t            = heap_slot[a];
    heap_slot[a] = heap_slot[b];
    heap_slot[b] = t;
  endfunction

  function automatic void heap_insert(logic signed [KEY_W-1:0] key, int src, int pos);
    int i;
    int p;
    if (heap_n >= LISTS) return;
    i = heap_n;
    heap_n++;
    heap_slot[i].key = key;
    heap_slot[i].src = LIST_W'(src);
    heap_slot[i].pos = POS_W'(pos);
    while (i > 0) begin
      p = (i - 1) / 2;
      if ($signed(heap_slot[p].key) > $signed(heap_slot[i].key)) begin
        swap_slots(p, i);
        i = p;
      end else begin
        break;
      end
    end
  endfunction

  function automatic void sift_root_down();
    int i;
    int l;
    int r;
    int m;
    i = 0;
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      m = i;
      if (l < heap_n && $signed(heap_slot[m].key) > $signed(heap_slot[l].key)) m = l;
      if (r < heap_n && $signed(heap_slot[m].key) > $signed(heap_slot[r].key)) m = r;
      if (m == i) break;
      swap_slots(i, m);
      i = m;
    end
  endfunction

  function automatic merge_reply_t apply_command(op_e_t op, logic signed [KEY_W-1:0] value,
                                                 logic [LIST_W-1:0] lid);
    merge_reply_t res;
    int           src;
    int           pos;
    res.value = '0;
    res.lst   = '0;
    res.last  = 1'b0;
    res.st    = ST_OK;
    case (op)
      OP_LOAD: begin
        if (merge_phase != PH_LOADING) begin
          res.st = ST_PHASE;
        end else if (int'(lid) >= LISTS || list_len[lid] >= LIST_DEPTH) begin
          res.st = ST_FULL;
        end else begin
          elem_mem[lid][list_len[lid]] = value;
          list_len[lid]++;
        end
      end
      OP_START: begin
        if (merge_phase != PH_LOADING) begin
          res.st = ST_PHASE;
        end else begin
          heap_n = 0;
          for (int s = 0; s < LISTS; s++)
            if (list_len[s] > 0) heap_insert(elem_mem[s][0], s, 0);
          merge_phase = PH_MERGING;
        end
      end
      OP_POP: begin
        if (merge_phase != PH_MERGING) begin
          res.st = ST_PHASE;
        end else if (heap_n == 0) begin
          res.st = ST_EMPTY;
        end else begin
          src       = int'(heap_slot[0].src);
          pos       = int'(heap_slot[0].pos);
          res.value = heap_slot[0].key;
          res.lst   = heap_slot[0].src;
          heap_n--;
          if (heap_n > 0) begin
            heap_slot[0] = heap_slot[heap_n];
            sift_root_down();
          end
          if (pos + 1 < list_len[src] && pos + 1 < LIST_DEPTH)
            heap_insert(elem_mem[src][pos + 1], src, pos + 1);
          res.last = (heap_n == 0);
        end
      end
      default: clear_model();
    endcase
    return res;
  endfunction

  function automatic void note_mismatch(string field, longint want, longint got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    fail_total++;
  endfunction

  always @(posedge clk) begin
    merge_reply_t want;
    if (rst) begin
      clear_model();
      reply_q.delete();
      fail_total = 0;
    end else begin
      if (req.valid === 1'b1 && req.ready === 1'b1)
        reply_q.push_back(apply_command(op_e_t'(req.op), req.value, req.list_id));
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected item, expected none, got value %0d list %0d status %0d",
                   $time, rsp.out_value, rsp.out_list, rsp.status);
          fail_total++;
        end else begin
          want = reply_q.pop_front();
          if (rsp.out_value !== want.value) note_mismatch("out_value", want.value, rsp.out_value);
          if (rsp.out_list !== want.lst) note_mismatch("out_list", want.lst, rsp.out_list);
          if (rsp.is_last !== want.last) note_mismatch("is_last", want.last, rsp.is_last);
          if (rsp.status !== want.st) note_mismatch("status", want.st, rsp.status);
        end
      end
    end
    errors      <= fail_total;
    outstanding <= reply_q.size();
  end

endmodule

// ----- verif/k_way_merge_heap_tb.sv -----
// ----------------------------------------------------------------------------
// k_way_merge_heap_tb
// Drives commands into the merge heap: a short directed pass over the phase
// errors, empty merges, ties and value extremes, then rounds of clear, load,
// start and pop with random, mostly sorted lists, one list overfilled, and
// scattered out-of-phase commands and aborted merges. The sender works in
// bursts, the receiver stalls in changing patterns; a checker compares replies.
// ----------------------------------------------------------------------------
module k_way_merge_heap_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kwm_pkg::*;

  localparam logic [1:0] STALL_NONE  = 2'd0;
  localparam logic [1:0] STALL_LIGHT = 2'd1;
  localparam logic [1:0] STALL_HEAVY = 2'd2;
  localparam logic [1:0] STALL_BEAT  = 2'd3;

  localparam int VAL_WIDE  = 0;
  localparam int VAL_TIGHT = 1;
  localparam int VAL_EDGE  = 2;

  localparam int RANDOM_ITEMS = 850;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  int         fail_count;
  int         in_flight;
  int         n_items = 0;
  int         burst_left = 0;
  logic [1:0] stall_mode = STALL_NONE;
  int         stall_left = 0;
  logic [3:0] tick = 4'd0;

  logic signed [KEY_W-1:0] run_vals [LISTS][LIST_DEPTH];
  int                      run_len [LISTS];
  int                      run_ptr [LISTS];

  kwm_req_if req_ch ();
  kwm_rsp_if rsp_ch ();

  k_way_merge_heap u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  k_way_merge_heap_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .errors      (fail_count),
    .outstanding (in_flight)
  );

  always #5ns clk = ~clk;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      stall_left <= $urandom_range(4, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    tick <= tick + 4'd1;
    case (stall_mode)
      STALL_NONE:  rsp_ch.ready <= 1'b1;
      STALL_LIGHT: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
      STALL_HEAVY: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
      default:     rsp_ch.ready <= (tick[2:1] != 2'b00);
    endcase
  end

  task automatic issue_cmd(input op_e_t op, input logic signed [KEY_W-1:0] value,
                           input logic [LIST_W-1:0] lid);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid   <= 1'b1;
    req_ch.op      <= op;
    req_ch.value   <= value;
    req_ch.list_id <= lid;
    n_items++;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
  endtask

  function automatic int pick_value(int style);
    case (style)
      VAL_WIDE:  return $urandom;
      VAL_TIGHT: return $urandom_range(0, 7) - 4;
      default: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  task automatic load_lists(input int max_len, input bit sorted, input int full_list,
                            output int total);
    int tmp [$];
    int style;
    int l;
    case ($urandom_range(0, 5))
      0, 1, 2: style = VAL_WIDE;
      3, 4:    style = VAL_TIGHT;
      default: style = VAL_EDGE;
    endcase
    total = 0;
    for (l = 0; l < LISTS; l++) begin
      tmp.delete();
      if (l == full_list) run_len[l] = LIST_DEPTH;
      else run_len[l] = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, max_len);
      for (int k = 0; k < run_len[l]; k++) tmp.push_back(pick_value(style));
      if (sorted) tmp.sort();
      for (int k = 0; k < run_len[l]; k++) run_vals[l][k] = tmp[k];
      run_ptr[l] = 0;
      total += run_len[l];
    end
    for (int left = total; left > 0; ) begin
      l = $urandom_range(0, LISTS - 1);
      if (run_ptr[l] < run_len[l]) begin
        issue_cmd(OP_LOAD, run_vals[l][run_ptr[l]], LIST_W'(l));
        run_ptr[l]++;
        left--;
      end
    end
  endtask

  task automatic merge_round(input int max_len, input int full_list);
    int total;
    int pops;
    int saved;
    bit sorted;
    sorted = ($urandom_range(0, 7) != 0);
    issue_cmd(OP_CLEAR, $urandom, LIST_W'($urandom));
    if ($urandom_range(0, 5) == 0) begin
      saved = n_items;
      issue_cmd(OP_POP, $urandom, LIST_W'($urandom));
      n_items = saved;
    end
    load_lists(max_len, sorted, full_list, total);
    if (full_list >= 0)
      repeat (2) issue_cmd(OP_LOAD, $urandom, LIST_W'(full_list));
    issue_cmd(OP_START, $urandom, LIST_W'($urandom));
    pops = total + $urandom_range(0, 2);
    for (int k = 0; k < pops; k++) begin
      if ($urandom_range(0, 15) == 0) begin
        saved = n_items;
        issue_cmd(($urandom_range(0, 1) == 0) ? OP_LOAD : OP_START, $urandom,
                  LIST_W'($urandom));
        n_items = saved;
      end
      if (full_list < 0 && $urandom_range(0, 39) == 0) break;
      issue_cmd(OP_POP, $urandom, LIST_W'($urandom));
    end
  endtask

  initial begin
    req_ch.valid   <= 1'b0;
    req_ch.op      <= OP_LOAD;
    req_ch.value   <= '0;
    req_ch.list_id <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    issue_cmd(OP_POP, 0, 3'd0);
    issue_cmd(OP_START, 0, 3'd0);
    issue_cmd(OP_POP, -1, 3'd7);
    issue_cmd(OP_LOAD, 5, 3'd2);
    issue_cmd(OP_START, 0, 3'd0);
    issue_cmd(OP_CLEAR, 0, 3'd0);
    issue_cmd(OP_LOAD, 32'h8000_0000, 3'd0);
    issue_cmd(OP_LOAD, 32'h7fff_ffff, 3'd0);
    issue_cmd(OP_LOAD, -1, 3'd7);
    issue_cmd(OP_LOAD, 32'h7fff_ffff, 3'd7);
    issue_cmd(OP_LOAD, 0, 3'd3);
    issue_cmd(OP_LOAD, -1, 3'd5);
    issue_cmd(OP_LOAD, 32'h8000_0000, 3'd1);
    issue_cmd(OP_LOAD, 32'h5555_5555, 3'd6);
    issue_cmd(OP_START, -1, 3'd7);
    repeat (9) issue_cmd(OP_POP, 32'haaaa_aaaa, 3'b101);
    settle();

    n_items = 0;
    for (int round = 0; n_items < RANDOM_ITEMS; round++) begin
      merge_round((round % 10 == 9) ? 20 : 6,
                  (round == 3) ? int'($urandom_range(0, LISTS - 1)) : -1);
      if (round % 4 == 0) settle();
    end
    settle();
    repeat (64) @(posedge clk);

    if (fail_count == 0) begin
      $display("k_way_merge_heap regression: pass");
    end else begin
      $display("k_way_merge_heap regression: fail");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("k_way_merge_heap regression: fail");
    $finish;
  end

endmodule
